### design/irbl_pkg.sv
package irbl_pkg;

   localparam int MAP_SIZE_DEF        = 22;
   localparam int READ_LIMIT_DEF      = 32;
   localparam int SETTINGS_END_DEF    = 16;
   localparam int TIME_UNIT_TICKS_DEF = 10;

   localparam int MAP_IDX_W = 5;
   localparam int ELAPSED_W = 12;

   localparam logic [1:0] KIND_ADDR = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   localparam int REG_LED_MODE = 7;
   localparam int REG_ON_TIME  = 8;
   localparam int REG_OFF_TIME = 9;
   localparam int REG_LOCK     = 'h14;
   localparam int REG_MODE     = 'h15;

   localparam logic [7:0] LED_MODE_DARK     = 8'd0;
   localparam logic [7:0] LED_MODE_STEADY   = 8'd1;
   localparam logic [7:0] LED_MODE_FLASH    = 8'd2;
   localparam logic [7:0] LED_MODE_PPS      = 8'd3;
   localparam logic [7:0] LED_MODE_LOCK     = 8'd4;
   localparam logic [7:0] LED_MODE_PPS_LOCK = 8'd5;

   localparam logic [7:0] DEF_LED_MODE = 8'd2;
   localparam logic [7:0] DEF_ON_TIME  = 8'd20;
   localparam logic [7:0] DEF_OFF_TIME = 8'd80;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   function automatic logic [7:0] reg_default(input logic [MAP_IDX_W-1:0] idx);
      logic [7:0] val;
      case (idx)
         5'd3:         val = 8'd1;
         5'd4:         val = 8'd10;
         5'd6:         val = 8'd1;
         5'd7:         val = DEF_LED_MODE;
         5'd8:         val = DEF_ON_TIME;
         5'd9:         val = DEF_OFF_TIME;
         default:      val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

### design/irbl_ram.sv
module irbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 22
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/i2c_register_bank_with_led_core.sv
// Channel  Ports         Payload
// request  req_tvalid    tuser: kind, first_read
//          req_tready    tdata: data_byte, pps_seen, lock_detect, pll_mode
// response rsp_tvalid    tdata: read_data, read_valid, settings_changed,
//          rsp_tready           function_changed, led_on
//
// One transaction in flight: accepted in the idle state, finished in the exec state,
// when the registered map RAM read data is available. A new transaction is
// accepted only after the previous one has finished.
// A full response register holds the finishing cycle until rsp_tready.
// Synchronous reset restores the register defaults through per-entry valid bits.
module i2c_register_bank_with_led_core
   #(
   parameter int MAP_SIZE        = irbl_pkg::MAP_SIZE_DEF,
   parameter int READ_LIMIT      = irbl_pkg::READ_LIMIT_DEF,
   parameter int SETTINGS_END    = irbl_pkg::SETTINGS_END_DEF,
   parameter int TIME_UNIT_TICKS = irbl_pkg::TIME_UNIT_TICKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // kind[1:0], first_read[2]
   input  logic [23:0] req_tdata,  // data_byte[7:0], pps_seen[8], lock_detect[9],
                                   // pll_mode[17:10], zero[23:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[7:0], read_valid[8], settings_changed[9],
                                   // function_changed[10], led_on[11], zero[15:12]
);
   import irbl_pkg::*;

   localparam int ADDR_W = $clog2(MAP_SIZE);
   localparam int CUR_W  = $clog2(MAP_SIZE + 1);
   localparam int CNT_W  = $clog2(READ_LIMIT + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [ADDR_W-1:0]    start_ff, start_in;
   logic [CUR_W-1:0]     wcur_ff, wcur_in;
   logic                 wopen_ff, wopen_in;
   logic                 fpend_ff, fpend_in;
   logic [CUR_W-1:0]     rcur_ff, rcur_in;
   logic [CNT_W-1:0]     rcnt_ff, rcnt_in;
   logic                 led_ff, led_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W-1:0] timeout_ff, timeout_in;
   logic                 pps_ff, pps_in;
   logic [MAP_SIZE-1:0]  valid_ff, valid_in;
   logic [7:0]           mode_ff, mode_in;
   logic [7:0]           on_ff, on_in;
   logic [7:0]           off_ff, off_in;
   logic                 lock_ff, lock_in;
   logic [7:0]           pllm_ff, pllm_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 sflag_ff, sflag_in;
   logic                 fflag_ff, fflag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic [1:0]           kind;
   logic                 first_read;
   logic [7:0]           data_byte;
   logic                 pps_seen;
   logic                 lock_detect;
   logic [7:0]           pll_mode;

   logic [CUR_W-1:0]     rd_cur;
   logic [CNT_W-1:0]     rd_cnt;
   logic                 rd_ok;
   logic                 wr_go;
   logic                 wr_ro;
   logic                 ram_we;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_addr;
   logic [7:0]           ram_q;
   logic [7:0]           rd_byte;
   logic                 slot_free;

   logic [ELAPSED_W-1:0] el_inc;
   logic                 pend;
   logic                 led_evt;
   logic                 lvl_on;
   logic                 lvl_keep;
   logic [ELAPSED_W-1:0] on_ticks;
   logic [ELAPSED_W-1:0] off_ticks;

   assign kind        = req_tuser[1:0];
   assign first_read  = req_tuser[2];
   assign data_byte   = req_tdata[7:0];
   assign pps_seen    = req_tdata[8];
   assign lock_detect = req_tdata[9];
   assign pll_mode    = req_tdata[17:10];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rd_cur = first_read ? CUR_W'(start_ff) : rcur_ff;
   assign rd_cnt = first_read ? '0 : rcnt_ff;
   assign rd_ok  = (rd_cnt < CNT_W'(READ_LIMIT)) && (rd_cur < CUR_W'(MAP_SIZE));

   assign wr_go = wopen_ff && (wcur_ff < CUR_W'(MAP_SIZE));
   assign wr_ro = (wcur_ff == CUR_W'(REG_LOCK)) || (wcur_ff == CUR_W'(REG_MODE));

   assign ram_we   = accept && (kind == KIND_DATA) && wr_go && !wr_ro;
   assign ram_re   = accept && (kind == KIND_READ) && rd_ok;
   assign ram_addr = (kind == KIND_DATA) ? wcur_ff[ADDR_W-1:0] : rd_cur[ADDR_W-1:0];

   irbl_ram #(
      .WIDTH (8),
      .DEPTH (MAP_SIZE)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (data_byte),
      .rdata (ram_q)
   );

   assign el_inc    = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + ELAPSED_W'(1) : elapsed_ff;
   assign pend      = pps_ff || pps_seen;
   assign led_evt   = (el_inc > timeout_ff) || pend;
   assign lvl_on    = (mode_ff == LED_MODE_STEADY) || (mode_ff == LED_MODE_FLASH) ||
                      (pend && mode_ff == LED_MODE_PPS) ||
                      (mode_ff == LED_MODE_LOCK && lock_detect) ||
                      (pend && mode_ff == LED_MODE_PPS_LOCK && lock_detect);
   assign lvl_keep  = !((mode_ff == LED_MODE_DARK) || (mode_ff == LED_MODE_FLASH) ||
                        (mode_ff == LED_MODE_PPS) ||
                        (mode_ff == LED_MODE_LOCK && !lock_detect) ||
                        (mode_ff == LED_MODE_PPS_LOCK));
   assign on_ticks  = ELAPSED_W'(on_ff * TIME_UNIT_TICKS);
   assign off_ticks = ELAPSED_W'(off_ff * TIME_UNIT_TICKS);

   always_comb begin
      if (!rd_ok_ff) begin
         rd_byte = 8'd0;
      end else if (rd_idx_ff == ADDR_W'(REG_LOCK)) begin
         rd_byte = {7'd0, lock_ff};
      end else if (rd_idx_ff == ADDR_W'(REG_MODE)) begin
         rd_byte = pllm_ff;
      end else if (valid_ff[rd_idx_ff]) begin
         rd_byte = ram_q;
      end else begin
         rd_byte = reg_default(MAP_IDX_W'(rd_idx_ff));
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      wcur_in      = wcur_ff;
      wopen_in     = wopen_ff;
      fpend_in     = fpend_ff;
      rcur_in      = rcur_ff;
      rcnt_in      = rcnt_ff;
      led_in       = led_ff;
      elapsed_in   = elapsed_ff;
      timeout_in   = timeout_ff;
      pps_in       = pps_ff;
      valid_in     = valid_ff;
      mode_in      = mode_ff;
      on_in        = on_ff;
      off_in       = off_ff;
      lock_in      = lock_ff;
      pllm_in      = pllm_ff;
      rd_ok_in     = rd_ok_ff;
      rd_idx_in    = rd_idx_ff;
      sflag_in     = sflag_ff;
      fflag_in     = fflag_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               rd_ok_in = 1'b0;
               sflag_in = 1'b0;
               fflag_in = 1'b0;
               case (kind)
                  KIND_ADDR: begin
                     if (data_byte < 8'(MAP_SIZE)) begin
                        start_in = data_byte[ADDR_W-1:0];
                        wcur_in  = CUR_W'(data_byte);
                        wopen_in = 1'b1;
                        fpend_in = 1'b1;
                     end else begin
                        wopen_in = 1'b0;
                        fpend_in = 1'b0;
                     end
                  end
                  KIND_DATA: begin
                     if (wopen_ff && fpend_ff) begin
                        fflag_in = 1'b1;
                        sflag_in = (CUR_W'(start_ff) < CUR_W'(SETTINGS_END));
                        fpend_in = 1'b0;
                     end
                     if (wr_go) begin
                        wcur_in = wcur_ff + CUR_W'(1);
                        if (!wr_ro) begin
                           valid_in[wcur_ff[ADDR_W-1:0]] = 1'b1;
                        end
                        if (wcur_ff == CUR_W'(REG_LED_MODE)) begin
                           mode_in = data_byte;
                        end
                        if (wcur_ff == CUR_W'(REG_ON_TIME)) begin
                           on_in = data_byte;
                        end
                        if (wcur_ff == CUR_W'(REG_OFF_TIME)) begin
                           off_in = data_byte;
                        end
                     end
                  end
                  KIND_READ: begin
                     if (first_read) begin
                        wopen_in = 1'b0;
                        fpend_in = 1'b0;
                     end
                     rcur_in   = rd_cur;
                     rcnt_in   = rd_cnt;
                     rd_ok_in  = rd_ok;
                     rd_idx_in = rd_cur[ADDR_W-1:0];
                     if (rd_ok) begin
                        rcur_in = rd_cur + CUR_W'(1);
                        rcnt_in = rd_cnt + CNT_W'(1);
                     end
                  end
                  KIND_TICK: begin
                     lock_in    = lock_detect;
                     pllm_in    = pll_mode;
                     elapsed_in = el_inc;
                     pps_in     = pend;
                     if (led_evt) begin
                        led_in     = led_ff ? lvl_keep : lvl_on;
                        timeout_in = led_ff ? off_ticks : on_ticks;
                        elapsed_in = '0;
                        pps_in     = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, led_ff, fflag_ff, sflag_ff, rd_ok_ff, rd_byte};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         wcur_ff      <= '0;
         wopen_ff     <= 1'b0;
         fpend_ff     <= 1'b0;
         rcur_ff      <= '0;
         rcnt_ff      <= '0;
         led_ff       <= 1'b0;
         elapsed_ff   <= '0;
         timeout_ff   <= '0;
         pps_ff       <= 1'b0;
         valid_ff     <= '0;
         mode_ff      <= DEF_LED_MODE;
         on_ff        <= DEF_ON_TIME;
         off_ff       <= DEF_OFF_TIME;
         lock_ff      <= 1'b0;
         pllm_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         wcur_ff      <= wcur_in;
         wopen_ff     <= wopen_in;
         fpend_ff     <= fpend_in;
         rcur_ff      <= rcur_in;
         rcnt_ff      <= rcnt_in;
         led_ff       <= led_in;
         elapsed_ff   <= elapsed_in;
         timeout_ff   <= timeout_in;
         pps_ff       <= pps_in;
         valid_ff     <= valid_in;
         mode_ff      <= mode_in;
         on_ff        <= on_in;
         off_ff       <= off_in;
         lock_ff      <= lock_in;
         pllm_ff      <= pllm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ok_ff    <= rd_ok_in;
      rd_idx_ff   <= rd_idx_in;
      sflag_ff    <= sflag_in;
      fflag_ff    <= fflag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_exec_follows_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff) |-> $past(accept))
      else $error("finishing cycle entered without an accepted transaction");

   a_wcur_bound: assert property (@(posedge clock) disable iff (reset)
      wcur_ff <= CUR_W'(MAP_SIZE))
      else $error("write cursor beyond map end");

   a_rcnt_bound: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= CNT_W'(READ_LIMIT))
      else $error("read count beyond limit");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[10] && !rsp_tdata[8])
      else $error("settings flag without function flag, or on a read");
`endif

endmodule

### tb/sv/i2c_register_bank_with_led_core_tb.sv
`timescale 1ns / 100ps

module i2c_register_bank_with_led_core_tb;
   import irbl_pkg::*;

   localparam int RANDOM_ITEMS   = 1530;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 600;
   localparam int SYNC_AT_ITEM   = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       first_read;
      logic       pps_seen;
      logic       lock_detect;
      logic [7:0] pll_mode;
   } bank_req_type;

   typedef struct packed {
      logic       led_on;
      logic       function_changed;
      logic       settings_changed;
      logic       read_valid;
      logic [7:0] read_data;
   } bank_result_type;

   typedef struct packed {
      bank_req_type    req;
      logic            typed;
      bank_result_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   logic [7:0]           bank_map [MAP_SIZE_DEF];
   logic [4:0]           start_reg;
   logic [4:0]           wr_cursor;
   logic                 wr_open;
   logic                 first_pending;
   logic [4:0]           rd_cursor;
   logic [5:0]           rd_count;
   logic                 led_level;
   logic [ELAPSED_W-1:0] led_elapsed;
   logic [ELAPSED_W-1:0] led_timeout;
   logic                 pps_pend;

   bank_result_type awaited_results [$];
   int              errors       = 0;
   int              sent         = 0;
   int              rsp_seen     = 0;
   int              stall_cycles = 0;

   i2c_register_bank_with_led_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic bank_result_type bank_predict(input bank_req_type r);
      bank_result_type res;
      logic [7:0]      mode;
      logic            lvl;
      res = '0;
      case (r.kind)
         KIND_ADDR: begin
            if (r.data_byte < MAP_SIZE_DEF) begin
               start_reg     = r.data_byte[4:0];
               wr_cursor     = r.data_byte[4:0];
               wr_open       = 1'b1;
               first_pending = 1'b1;
            end else begin
               wr_open       = 1'b0;
               first_pending = 1'b0;
            end
         end
         KIND_DATA: begin
            if (wr_open) begin
               if (first_pending) begin
                  res.function_changed = 1'b1;
                  res.settings_changed = start_reg < SETTINGS_END_DEF;
                  first_pending        = 1'b0;
               end
               if (wr_cursor < MAP_SIZE_DEF) begin
                  if (wr_cursor != REG_LOCK && wr_cursor != REG_MODE)
                     bank_map[wr_cursor] = r.data_byte;
                  wr_cursor++;
               end
            end
         end
         KIND_READ: begin
            if (r.first_read) begin
               rd_cursor     = start_reg;
               rd_count      = '0;
               wr_open       = 1'b0;
               first_pending = 1'b0;
            end
            if (rd_count < READ_LIMIT_DEF && rd_cursor < MAP_SIZE_DEF) begin
               res.read_data  = bank_map[rd_cursor];
               res.read_valid = 1'b1;
               rd_cursor++;
               rd_count++;
            end
         end
         default: begin
            mode = bank_map[REG_LED_MODE];
            if (led_elapsed != ELAPSED_MAX)
               led_elapsed++;
            pps_pend = pps_pend | r.pps_seen;
            if (led_elapsed > led_timeout || pps_pend) begin
               if (!led_level) begin
                  lvl = mode == LED_MODE_STEADY || mode == LED_MODE_FLASH ||
                        (pps_pend && mode == LED_MODE_PPS) ||
                        (mode == LED_MODE_LOCK && r.lock_detect) ||
                        (pps_pend && mode == LED_MODE_PPS_LOCK && r.lock_detect);
                  led_timeout = ELAPSED_W'(bank_map[REG_ON_TIME] * TIME_UNIT_TICKS_DEF);
               end else begin
                  lvl = !(mode == LED_MODE_DARK || mode == LED_MODE_FLASH ||
                          mode == LED_MODE_PPS ||
                          (mode == LED_MODE_LOCK && !r.lock_detect) ||
                          mode == LED_MODE_PPS_LOCK);
                  led_timeout = ELAPSED_W'(bank_map[REG_OFF_TIME] * TIME_UNIT_TICKS_DEF);
               end
               led_level   = lvl;
               led_elapsed = '0;
               pps_pend    = 1'b0;
            end
            bank_map[REG_LOCK] = {7'd0, r.lock_detect};
            bank_map[REG_MODE] = r.pll_mode;
         end
      endcase
      res.led_on = led_level;
      return res;
   endfunction

   function automatic directed_row_type mk(input logic [1:0] kind, input logic [7:0] data_byte,
                                           input logic first, input logic pps, input logic ld,
                                           input logic [7:0] mode, input logic typed,
                                           input logic [7:0] rdata, input logic rvalid,
                                           input logic schg, input logic fchg, input logic led);
      directed_row_type row;
      row.req   = '{kind, data_byte, first, pps, ld, mode};
      row.typed = typed;
      row.want  = '{led, fchg, schg, rvalid, rdata};
      return row;
   endfunction

   function automatic bank_req_type rand_req();
      bank_req_type r;
      r.kind        = 2'($urandom_range(0, 3));
      r.data_byte   = 8'($urandom_range(0, 255));
      r.first_read  = 1'($urandom_range(0, 1));
      r.pps_seen    = 1'($urandom_range(0, 1));
      r.lock_detect = 1'($urandom_range(0, 1));
      r.pll_mode    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic int pick_gap(input logic calm);
      int u;
      u = $urandom_range(0, 9);
      if (calm || u < 6)
         return 0;
      if (u < 9)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_txn(input bank_req_type r, input logic typed,
                           input bank_result_type want, input int gap);
      bank_result_type pred;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= {r.first_read, r.kind};
      req_tdata  <= {6'd0, r.pll_mode, r.lock_detect, r.pps_seen, r.data_byte};
      do @(posedge clock); while (!req_tready);
      pred = bank_predict(r);
      awaited_results.push_back(typed ? want : pred);
      sent++;
   endtask

   initial begin : stimulus
      directed_row_type dir_rows [$];
      bank_req_type     r;
      logic             calm;
      int               cur;
      int               n;
      int               u;
      logic             synced;

      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      calm       = 1'b0;
      synced     = 1'b0;

      for (int i = 0; i < MAP_SIZE_DEF; i++)
         bank_map[i] = 8'd0;
      bank_map[3]            = 8'd1;
      bank_map[4]            = 8'd10;
      bank_map[6]            = 8'd1;
      bank_map[REG_LED_MODE] = 8'd2;
      bank_map[REG_ON_TIME]  = 8'd20;
      bank_map[REG_OFF_TIME] = 8'd80;
      start_reg     = '0;
      wr_cursor     = '0;
      wr_open       = 1'b0;
      first_pending = 1'b0;
      rd_cursor     = '0;
      rd_count      = '0;
      led_level     = 1'b0;
      led_elapsed   = '0;
      led_timeout   = '0;
      pps_pend      = 1'b0;

      dir_rows = '{
         mk(KIND_READ, 8'h00, 1, 0, 0, 8'h00, 1, 8'h00, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 1, 0, 0, 0),
         mk(KIND_DATA, 8'hFF, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_ADDR, 8'hFF, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_ADDR, 8'd22, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_ADDR, 8'd3,  0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_DATA, 8'hA5, 0, 0, 0, 8'h00, 1, 8'h00, 0, 1, 1, 0),
         mk(KIND_DATA, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_READ, 8'h00, 1, 0, 0, 8'h00, 1, 8'hA5, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 1, 0, 0, 0),
         mk(KIND_ADDR, 8'h13, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_DATA, 8'h11, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 1, 0),
         mk(KIND_DATA, 8'h22, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_DATA, 8'h33, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_DATA, 8'h44, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_TICK, 8'h00, 0, 0, 1, 8'hFF, 1, 8'h00, 0, 0, 0, 1),
         mk(KIND_TICK, 8'hFF, 1, 1, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_READ, 8'h00, 1, 0, 0, 8'h00, 1, 8'h11, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_TICK, 8'h00, 0, 0, 1, 8'h5A, 0, 8'h00, 0, 0, 0, 0),
         mk(KIND_ADDR, 8'd21, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0),
         mk(KIND_DATA, 8'h77, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 1, 0),
         mk(KIND_READ, 8'h00, 1, 0, 0, 8'h00, 1, 8'h5A, 1, 0, 0, 0),
         mk(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 1, 8'h00, 0, 0, 0, 0)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_txn(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, pick_gap(calm));

      while (sent < dir_rows.size() + RANDOM_ITEMS) begin
         if (!synced && sent >= SYNC_AT_ITEM) begin
            synced = 1'b1;
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (awaited_results.size() != 0) @(posedge clock);
         end
         calm = ($urandom_range(0, 4) == 0);
         u    = $urandom_range(0, 19);
         if (u < 8) begin
            r      = rand_req();
            r.kind = KIND_ADDR;
            case ($urandom_range(0, 9))
               0, 1, 2: r.data_byte = 8'($urandom_range(REG_LED_MODE, REG_OFF_TIME));
               3:       r.data_byte = 8'($urandom_range(18, 21));
               4:       r.data_byte = 8'($urandom_range(MAP_SIZE_DEF, 255));
               default: r.data_byte = 8'($urandom_range(0, MAP_SIZE_DEF - 1));
            endcase
            send_txn(r, 1'b0, '0, pick_gap(calm));
            cur = r.data_byte;
            n   = $urandom_range(1, 6);
            repeat (n) begin
               r      = rand_req();
               r.kind = KIND_DATA;
               if (cur == REG_LED_MODE && $urandom_range(0, 3) != 0)
                  r.data_byte = 8'($urandom_range(0, 7));
               else if ((cur == REG_ON_TIME || cur == REG_OFF_TIME) && $urandom_range(0, 3) != 0)
                  r.data_byte = 8'($urandom_range(0, 4));
               send_txn(r, 1'b0, '0, pick_gap(calm));
               cur++;
            end
         end else if (u < 13) begin
            r            = rand_req();
            r.kind       = KIND_READ;
            r.first_read = 1'b1;
            send_txn(r, 1'b0, '0, pick_gap(calm));
            n = $urandom_range(0, 24);
            repeat (n) begin
               r            = rand_req();
               r.kind       = KIND_READ;
               r.first_read = ($urandom_range(0, 15) == 0);
               send_txn(r, 1'b0, '0, pick_gap(calm));
            end
         end else if (u < 19) begin
            n = $urandom_range(1, 25);
            repeat (n) begin
               r          = rand_req();
               r.kind     = KIND_TICK;
               r.pps_seen = ($urandom_range(0, 5) == 0);
               send_txn(r, 1'b0, '0, pick_gap(calm));
            end
         end else begin
            send_txn(rand_req(), 1'b0, '0, pick_gap(calm));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : rsp_side
      int   stall_left;
      int   calm_left;
      logic calm;
      logic held;
      rsp_tready = 1'b0;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= HOLD_AFTER) begin
            held       = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (calm_left == 0) begin
            calm_left = $urandom_range(50, 300);
            calm      = ($urandom_range(0, 3) == 0);
         end
         calm_left--;
         if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      bank_result_type got;
      bank_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         rsp_seen++;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected transaction, rsp_tdata %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            if (got.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h got %h", $time, want.read_data,
                        got.read_data);
               errors++;
            end
            if (got.read_valid !== want.read_valid) begin
               $display("%0t: read_valid expected %b got %b", $time, want.read_valid,
                        got.read_valid);
               errors++;
            end
            if (got.settings_changed !== want.settings_changed) begin
               $display("%0t: settings_changed expected %b got %b", $time,
                        want.settings_changed, got.settings_changed);
               errors++;
            end
            if (got.function_changed !== want.function_changed) begin
               $display("%0t: function_changed expected %b got %b", $time,
                        want.function_changed, got.function_changed);
               errors++;
            end
            if (got.led_on !== want.led_on) begin
               $display("%0t: led_on expected %b got %b", $time, want.led_on, got.led_on);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
